// ----- rtl/mcop_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// mcop_pkg
// Shared types, constants and tables of the option pricer.
// ============================================================================
package mcop_pkg;

    localparam int PRICE_FRAC_BITS  = 16;
    localparam int SAMPLE_FRAC_BITS = 12;
    localparam int MAX_STEPS        = 256;
    localparam int EXP_FRAC         = 28;
    localparam int TAYLOR_TERMS     = 12;
    localparam int MAX_PATHS        = 1048576;
    localparam int DISC_ONE         = 65536;
    localparam int FIFO_DEPTH       = 2;
    localparam int FIFO_PTR_W       = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W       = $clog2(FIFO_DEPTH + 1);

    localparam logic [27:0] LN2_Q28 = 28'd186065279;
    localparam logic [31:0] U32MAX  = 32'hFFFF_FFFF;

    // Register indexes of the configuration port
    localparam logic [3:0] REG_DRIFT    = 4'd0;
    localparam logic [3:0] REG_VOL      = 4'd1;
    localparam logic [3:0] REG_DISCOUNT = 4'd2;
    localparam logic [3:0] REG_SPOT     = 4'd3;
    localparam logic [3:0] REG_STRIKE   = 4'd4;
    localparam logic [3:0] REG_PUT      = 4'd5;
    localparam logic [3:0] REG_STEPS    = 4'd6;
    localparam logic [3:0] REG_PATHS    = 4'd7;

    // log-domain step exponent, Q28
    typedef logic signed [34:0] t_x;

    typedef struct packed {
        logic signed [30:0] drift;
        logic [29:0]        vol;
        logic [16:0]        discount;
        logic [31:0]        spot;
        logic [31:0]        strike;
        logic               put;
        logic [8:0]         steps;
        logic [20:0]        paths;
    } t_cfg;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [20:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } t_div_rsp;

    // floor(2^32 / i) for the Taylor term divisors; term 1 bypasses it
    function automatic logic [31:0] recip(input logic [3:0] i);
        logic [31:0] v;
        case (i)
            4'd2:    v = 32'd2147483648;
            4'd3:    v = 32'd1431655765;
            4'd4:    v = 32'd1073741824;
            4'd5:    v = 32'd858993459;
            4'd6:    v = 32'd715827882;
            4'd7:    v = 32'd613566756;
            4'd8:    v = 32'd536870912;
            4'd9:    v = 32'd477218588;
            4'd10:   v = 32'd429496729;
            4'd11:   v = 32'd390451572;
            4'd12:   v = 32'd357913941;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/mcop_in_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// mcop_in_if
// Sample channel: valid/ready with one Gaussian sample per transaction.
// ============================================================================
interface mcop_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] gauss_sample;

    modport source (output valid, output gauss_sample, input ready);
    modport sink   (input valid, input gauss_sample, output ready);
endinterface

// ----- rtl/mcop_out_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// mcop_out_if
// Result channel: valid/ready with one block estimate per transaction.
// ============================================================================
interface mcop_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] block_number;
    logic [31:0] running_mean;
    logic [31:0] standard_error;

    modport source (output valid, output block_number, output running_mean,
                    output standard_error, input ready);
    modport sink   (input valid, input block_number, input running_mean,
                    input standard_error, output ready);
endinterface

// ----- rtl/mcop_fifo.sv -----
`timescale 1ns / 1ps
// ============================================================================
// mcop_fifo
// Short queue of step exponents between front and back.
// ============================================================================
module mcop_fifo
    import mcop_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_x   i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_x   o_data
);
    t_x                    r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;

    assign o_full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + FIFO_CNT_W'(i_push && !o_full)
                               - FIFO_CNT_W'(i_pop && !o_empty);
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count out of range");

endmodule

// ----- rtl/mcop_front.sv -----
`timescale 1ns / 1ps
// ============================================================================
// mcop_front
// Accepts samples and forms the step exponent drift + vol*z.
// ============================================================================
module mcop_front
    import mcop_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    mcop_in_if.sink i_gauss,
    input  t_cfg i_cfg,
    output logic o_push,
    output t_x   o_x,
    input  logic i_full
);
    logic signed [46:0] r_vz;
    logic               r_vz_valid;
    logic               w_accept;

    assign o_push        = r_vz_valid && !i_full;
    assign i_gauss.ready = !r_vz_valid || !i_full;
    assign w_accept      = i_gauss.valid && i_gauss.ready;
    // floor shift of the product, then the signed drift
    assign o_x = 35'(i_cfg.drift) + 35'(r_vz >>> SAMPLE_FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_vz <= 47'($signed({1'b0, i_cfg.vol})) * 47'(i_gauss.gauss_sample);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vz_valid <= 1'b0;
        end else if (w_accept) begin
            r_vz_valid <= 1'b1;
        end else if (o_push) begin
            r_vz_valid <= 1'b0;
        end
    end

endmodule

// ----- rtl/mcop_divider.sv -----
`timescale 1ns / 1ps
// ============================================================================
// mcop_divider
// Shared restoring divider, 64-bit dividend by 21-bit divisor, 1 bit/cycle.
// ============================================================================
module mcop_divider
    import mcop_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_quo;
    logic [20:0] r_rem;
    logic [20:0] r_div;
    logic [21:0] w_trial;
    logic        w_ge;

    assign w_trial        = {r_rem, r_quo[63]};
    assign w_ge           = (w_trial >= {1'b0, r_div});
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? 21'(w_trial - {1'b0, r_div}) : w_trial[20:0];
            r_quo <= {r_quo[62:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/mcop_back.sv -----
`timescale 1ns / 1ps
// ============================================================================
// mcop_back
// Step sequencer: exp by range reduction and Taylor sum, path payoff,
// block statistics and the result register.
// ============================================================================
module mcop_back
    import mcop_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_empty,
    input  t_x       i_x,
    output logic     o_pop,
    output t_div_req o_div_req,
    input  t_div_rsp i_div_rsp,
    mcop_out_if.source o_result
);
    localparam logic [4:0] S_IDLE = 5'd0,  S_RED  = 5'd1,  S_KR   = 5'd2,
                           S_TMUL = 5'd3,  S_TREC = 5'd4,  S_TFIX = 5'd5,
                           S_PMUL = 5'd6,  S_PSH  = 5'd7,  S_PAY  = 5'd8,
                           S_ACC  = 5'd9,  S_AVG  = 5'd10, S_SQ   = 5'd11,
                           S_UPD  = 5'd12, S_MEAN = 5'd13, S_MSQ  = 5'd14,
                           S_M2   = 5'd15, S_VAR0 = 5'd16, S_VAR  = 5'd17,
                           S_SQRT = 5'd18, S_EMIT = 5'd19;

    logic [4:0]  r_state;
    // path and run state
    logic [31:0] r_price;
    logic [8:0]  r_step_cnt;
    logic [55:0] r_sum;
    logic [20:0] r_path_cnt;
    logic [15:0] r_blk_cnt;
    logic [47:0] r_mean_sum;
    logic [63:0] r_msq_sum;
    // working registers
    logic              r_neg;
    logic [34:0]       r_red;
    logic [2:0]        r_j;
    logic [6:0]        r_q;
    logic signed [7:0] r_k;
    logic [27:0]       r_r;
    logic [28:0]       r_term;
    logic [29:0]       r_e;
    logic [3:0]        r_i;
    logic [28:0]       r_t;
    logic [28:0]       r_qe;
    logic [61:0]       r_prod;
    logic [48:0]       r_pp;
    logic [31:0]       r_avg;
    logic [63:0]       r_sqp;
    logic [31:0]       r_mean;
    logic [63:0]       r_msq;
    logic [63:0]       r_sq_v;
    logic [63:0]       r_sq_res;
    logic [4:0]        r_sq_c;
    logic [31:0]       r_err;
    t_div_req          r_div_req;
    logic              r_out_valid;
    logic [15:0]       r_out_blk;
    logic [31:0]       r_out_mean;
    logic [31:0]       r_out_err;

    logic [34:0]       w_cmp;
    logic [8:0]        w_steps;
    logic [20:0]       w_paths;
    logic [8:0]        w_step_n;
    logic [20:0]       w_path_n;
    logic [55:0]       w_sum_n;
    logic [28:0]       w_fix_rem;
    logic [28:0]       w_fix_q;
    logic signed [8:0] w_sh;
    logic [31:0]       w_new_price;
    logic [31:0]       w_payoff;
    logic [16:0]       w_disc;
    logic [47:0]       w_sq;
    logic [63:0]       w_msq_sum_n;
    logic [47:0]       w_mean_sum_n;
    logic [47:0]       w_mean2;
    logic [63:0]       w_var;
    logic [63:0]       w_bit;
    logic [63:0]       w_sq_trial;
    logic [63:0]       w_sq_res_n;
    logic              w_out_free;

    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign o_div_req = r_div_req;

    assign w_cmp   = 35'(LN2_Q28) << r_j;
    assign w_steps = (i_cfg.steps == '0) ? 9'd1 :
                     (i_cfg.steps > 9'(MAX_STEPS)) ? 9'(MAX_STEPS) : i_cfg.steps;
    assign w_paths = (i_cfg.paths == '0) ? 21'd1 :
                     (i_cfg.paths > 21'(MAX_PATHS)) ? 21'(MAX_PATHS) : i_cfg.paths;
    assign w_step_n = r_step_cnt + 1'b1;
    assign w_path_n = r_path_cnt + 1'b1;
    assign w_sum_n  = r_sum + 56'(r_pp >> 16);

    // reciprocal estimate is at most one low
    assign w_fix_rem = r_t - 29'(r_qe * 33'(r_i));
    assign w_fix_q   = r_qe + 29'(w_fix_rem >= 29'(r_i));

    // price * e / 2^(28-k), saturating
    assign w_sh = 9'sd28 - 9'(r_k);
    always_comb begin
        logic [61:0] v;
        logic [5:0]  m;
        v = '0;
        m = '0;
        if (!w_sh[8]) begin
            if (w_sh >= 9'sd64) begin
                w_new_price = '0;
            end else begin
                v = r_prod >> w_sh[5:0];
                w_new_price = (v > 62'(U32MAX)) ? U32MAX : v[31:0];
            end
        end else begin
            m = 6'(-w_sh);
            if (r_prod == '0) begin
                w_new_price = '0;
            end else if (m >= 6'd32 || r_prod > 62'(U32MAX >> m)) begin
                w_new_price = U32MAX;
            end else begin
                w_new_price = 32'(r_prod << m);
            end
        end
    end

    assign w_payoff = i_cfg.put ?
                      ((i_cfg.strike > r_price) ? i_cfg.strike - r_price : '0) :
                      ((r_price > i_cfg.strike) ? r_price - i_cfg.strike : '0);
    assign w_disc   = (i_cfg.discount > 17'(DISC_ONE)) ? 17'(DISC_ONE) : i_cfg.discount;

    assign w_sq         = 48'(r_sqp >> PRICE_FRAC_BITS);
    assign w_mean_sum_n = r_mean_sum + 48'(r_avg);
    assign w_msq_sum_n  = (r_msq_sum > ~64'(w_sq)) ? '1 : r_msq_sum + 64'(w_sq);
    assign w_mean2      = 48'(r_sqp >> PRICE_FRAC_BITS);
    assign w_var        = (r_msq > 64'(w_mean2)) ? r_msq - 64'(w_mean2) : '0;

    assign w_bit      = 64'd1 << {r_sq_c, 1'b0};
    assign w_sq_trial = r_sq_res + w_bit;
    assign w_sq_res_n = (r_sq_v >= w_sq_trial) ? (r_sq_res >> 1) + w_bit : r_sq_res >> 1;

    assign w_out_free = !r_out_valid || o_result.ready;

    assign o_result.valid          = r_out_valid;
    assign o_result.block_number   = r_out_blk;
    assign o_result.running_mean   = r_out_mean;
    assign o_result.standard_error = r_out_err;

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_neg <= i_x[34];
                r_red <= i_x[34] ? 35'(~i_x) : 35'(i_x);
                r_j   <= 3'd6;
                r_q   <= '0;
            end
            S_RED: begin
                if (r_red >= w_cmp) begin
                    r_red    <= r_red - w_cmp;
                    r_q[r_j] <= 1'b1;
                end
                r_j <= r_j - 1'b1;
            end
            S_KR: begin
                r_k    <= r_neg ? -8'($signed({1'b0, r_q})) - 8'sd1
                                : 8'($signed({1'b0, r_q}));
                r_r    <= r_neg ? LN2_Q28 - 28'd1 - r_red[27:0] : r_red[27:0];
                r_term <= 29'(1) << EXP_FRAC;
                r_e    <= 30'(1) << EXP_FRAC;
                r_i    <= 4'd1;
            end
            S_TMUL: r_t <= 29'((57'(r_term) * 57'(r_r)) >> EXP_FRAC);
            S_TREC: r_qe <= (r_i == 4'd1) ? r_t : 29'((61'(r_t) * 61'(recip(r_i))) >> 32);
            S_TFIX: begin
                r_term <= w_fix_q;
                r_e    <= r_e + 30'(w_fix_q);
                r_i    <= r_i + 1'b1;
            end
            S_PMUL: r_prod <= 62'(r_price) * 62'(r_e);
            S_PAY:  r_pp <= 49'(w_payoff) * 49'(w_disc);
            S_AVG: begin
                if (i_div_rsp.done) begin
                    r_avg <= (i_div_rsp.quotient > 64'(U32MAX)) ? U32MAX
                                                                : i_div_rsp.quotient[31:0];
                end
            end
            S_SQ:   r_sqp <= 64'(r_avg) * 64'(r_avg);
            S_MEAN: begin
                if (i_div_rsp.done) begin
                    r_mean <= (i_div_rsp.quotient > 64'(U32MAX)) ? U32MAX
                                                                 : i_div_rsp.quotient[31:0];
                end
            end
            S_MSQ:  if (i_div_rsp.done) r_msq <= i_div_rsp.quotient;
            S_M2:   r_sqp <= 64'(r_mean) * 64'(r_mean);
            S_VAR0: r_err <= '0;
            S_VAR: begin
                if (i_div_rsp.done) begin
                    r_sq_v   <= ((i_div_rsp.quotient > (64'hFFFF_FFFF_FFFF_FFFF >> PRICE_FRAC_BITS))
                                 ? (64'hFFFF_FFFF_FFFF_FFFF >> PRICE_FRAC_BITS)
                                 : i_div_rsp.quotient) << PRICE_FRAC_BITS;
                    r_sq_res <= '0;
                    r_sq_c   <= 5'd31;
                end
            end
            S_SQRT: begin
                if (r_sq_v >= w_sq_trial) begin
                    r_sq_v <= r_sq_v - w_sq_trial;
                end
                r_sq_res <= w_sq_res_n;
                r_sq_c   <= r_sq_c - 1'b1;
                r_err    <= w_sq_res_n[31:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_price     <= 32'd6553600;
            r_step_cnt  <= '0;
            r_sum       <= '0;
            r_path_cnt  <= '0;
            r_blk_cnt   <= '0;
            r_mean_sum  <= '0;
            r_msq_sum   <= '0;
            r_div_req   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // start is a one-cycle pulse; no new request is issued in that cycle
            if (r_div_req.start) begin
                r_div_req.start <= 1'b0;
            end
            if (r_state == S_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: if (!i_empty) r_state <= S_RED;
                S_RED:  if (r_j == 3'd0) r_state <= S_KR;
                S_KR:   r_state <= S_TMUL;
                S_TMUL: r_state <= S_TREC;
                S_TREC: r_state <= S_TFIX;
                S_TFIX: r_state <= (r_i == 4'(TAYLOR_TERMS)) ? S_PMUL : S_TMUL;
                S_PMUL: r_state <= S_PSH;
                S_PSH: begin
                    r_price <= w_new_price;
                    if (w_step_n < w_steps) begin
                        r_step_cnt <= w_step_n;
                        r_state    <= S_IDLE;
                    end else begin
                        r_state <= S_PAY;
                    end
                end
                S_PAY: r_state <= S_ACC;
                S_ACC: begin
                    r_price    <= i_cfg.spot;
                    r_step_cnt <= '0;
                    if (w_path_n < w_paths) begin
                        r_sum      <= w_sum_n;
                        r_path_cnt <= w_path_n;
                        r_state    <= S_IDLE;
                    end else begin
                        r_sum      <= '0;
                        r_path_cnt <= '0;
                        r_div_req  <= '{start: 1'b1, dividend: 64'(w_sum_n), divisor: w_paths};
                        r_state    <= S_AVG;
                    end
                end
                S_AVG: if (i_div_rsp.done) r_state <= S_SQ;
                S_SQ:  r_state <= S_UPD;
                S_UPD: begin
                    r_mean_sum <= w_mean_sum_n;
                    r_msq_sum  <= w_msq_sum_n;
                    r_div_req  <= '{start: 1'b1, dividend: 64'(w_mean_sum_n),
                                    divisor: 21'(r_blk_cnt) + 21'd1};
                    r_state    <= S_MEAN;
                end
                S_MEAN: begin
                    if (i_div_rsp.done) begin
                        r_div_req <= '{start: 1'b1, dividend: r_msq_sum,
                                       divisor: 21'(r_blk_cnt) + 21'd1};
                        r_state   <= S_MSQ;
                    end
                end
                S_MSQ: if (i_div_rsp.done) r_state <= S_M2;
                S_M2:  r_state <= S_VAR0;
                S_VAR0: begin
                    if (r_blk_cnt == '0) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_div_req <= '{start: 1'b1, dividend: w_var, divisor: 21'(r_blk_cnt)};
                        r_state   <= S_VAR;
                    end
                end
                S_VAR:  if (i_div_rsp.done) r_state <= S_SQRT;
                S_SQRT: if (r_sq_c == '0) r_state <= S_EMIT;
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_blk   <= r_blk_cnt;
                        r_out_mean  <= r_mean;
                        r_out_err   <= r_err;
                        if (r_blk_cnt == 16'hFFFF) begin
                            r_blk_cnt  <= '0;
                            r_mean_sum <= '0;
                            r_msq_sum  <= '0;
                        end else begin
                            r_blk_cnt <= r_blk_cnt + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_rsp.done |-> (r_state == S_AVG || r_state == S_MEAN ||
                            r_state == S_MSQ || r_state == S_VAR))
        else $error("divider finished with no sequencer waiting");

    a_pop_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_RED))
        else $error("popped exponent not taken into reduction");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step_cnt < 9'(MAX_STEPS))
        else $error("step counter past its limit");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !w_out_free) |=> $stable(r_out_blk))
        else $error("result overwritten while pending");

endmodule

// ----- rtl/monte_carlo_option_pricer.sv -----
`timescale 1ns / 1ps
// ============================================================================
// monte_carlo_option_pricer
// Monte Carlo European option pricer, Q16.16 fixed point.
// ============================================================================
// Each Gaussian sample transaction advances the path price by
// exp(drift + vol*z). In the back end a sample is picked from the queue,
// then goes through range reduction by ln2, a setup step, the 12-term
// Taylor sum (multiply, reciprocal divide, correct per term) and the price
// multiply and saturating shift. A path end adds the payoff multiply and
// the accumulate. A block end adds four divisions on the shared divider
// (block average, mean, mean of squares, variance by block index) and an
// integer square root; the first block of a run skips the last division
// and the root. The front end takes a new sample each cycle into a
// two-entry queue, so it stalls only when the back end falls behind. The
// result register holds one pending block estimate while work continues.
// Configuration is written by index 0..7 through i_cfg_we/i_cfg_idx/
// i_cfg_data; higher indexes are ignored. Write it only while idle.
// ============================================================================
module monte_carlo_option_pricer
    import mcop_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    mcop_in_if.sink     i_gauss,
    mcop_out_if.source  o_result
);
    t_cfg     r_cfg;
    logic     w_push;
    t_x       w_push_x;
    logic     w_full;
    logic     w_empty;
    logic     w_pop;
    t_x       w_pop_x;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    // configuration registers, reset to their documented defaults
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drift    <= '0;
            r_cfg.vol      <= 30'd26843546;
            r_cfg.discount <= 17'd59298;
            r_cfg.spot     <= 32'd6553600;
            r_cfg.strike   <= 32'd6553600;
            r_cfg.put      <= 1'b0;
            r_cfg.steps    <= 9'd1;
            r_cfg.paths    <= 21'd10000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DRIFT:    r_cfg.drift    <= $signed(i_cfg_data[30:0]);
                REG_VOL:      r_cfg.vol      <= i_cfg_data[29:0];
                REG_DISCOUNT: r_cfg.discount <= i_cfg_data[16:0];
                REG_SPOT:     r_cfg.spot     <= i_cfg_data;
                REG_STRIKE:   r_cfg.strike   <= i_cfg_data;
                REG_PUT:      r_cfg.put      <= i_cfg_data[0];
                REG_STEPS:    r_cfg.steps    <= i_cfg_data[8:0];
                REG_PATHS:    r_cfg.paths    <= i_cfg_data[20:0];
                default: ;
            endcase
        end
    end

    // front: sample intake and exponent forming
    mcop_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gauss (i_gauss),
        .i_cfg   (r_cfg),
        .o_push  (w_push),
        .o_x     (w_push_x),
        .i_full  (w_full)
    );

    // decoupling queue
    mcop_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_x),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_pop_x)
    );

    // back: price recurrence, payoff and block statistics
    mcop_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_empty   (w_empty),
        .i_x       (w_pop_x),
        .o_pop     (w_pop),
        .o_div_req (w_div_req),
        .i_div_rsp (w_div_rsp),
        .o_result  (o_result)
    );

    // shared long divider for all block-end divisions
    mcop_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

endmodule

// ----- verif/monte_carlo_option_pricer_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// monte_carlo_option_pricer_checker
// Passive predictor and scoreboard for the option pricer.
// ============================================================================
// Mirrors configuration writes, advances its own path/block state on every
// accepted sample transaction and compares each result transaction with the
// oldest predicted block estimate.
// ============================================================================
module monte_carlo_option_pricer_checker
    import mcop_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    mcop_in_if          gauss_ch,
    mcop_out_if         result_ch,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic [15:0] block_number;
        logic [31:0] running_mean;
        logic [31:0] standard_error;
    } t_estimate;

    localparam longint LN2 = longint'(LN2_Q28);
    localparam logic [63:0] ALL_ONES = '1;

    // mirrored registers
    logic signed [30:0] drift_q;
    logic [29:0]        vol_q;
    logic [16:0]        disc_q;
    logic [31:0]        spot_q;
    logic [31:0]        strike_q;
    logic               put_q;
    logic [8:0]         steps_q;
    logic [20:0]        paths_q;

    // predicted pricer state
    logic [31:0] price_q;
    int unsigned step_cnt;
    logic [63:0] payoff_sum;
    int unsigned path_cnt;
    int unsigned block_cnt;
    logic [63:0] mean_sum;
    logic [63:0] sq_sum;

    t_estimate estimates_q[$];
    int        fails;

    assign o_fail_count = fails;
    assign o_pending    = estimates_q.size();

    // price * exp(x), x in Q28, saturating at 32 bits
    function automatic logic [31:0] grow_price(input logic [31:0] price,
                                               input longint x);
        longint      k, r, sh;
        logic [63:0] term, e, prod;
        if (x >= 0) begin
            k = x / LN2;
        end else begin
            k = -((-x + LN2 - 1) / LN2);
        end
        r    = x - k * LN2;
        term = 64'd1 << EXP_FRAC;
        e    = term;
        for (int i = 1; i <= TAYLOR_TERMS; i++) begin
            term = ((term * r) >> EXP_FRAC) / i;
            e    = e + term;
        end
        prod = {32'd0, price} * e;
        sh   = EXP_FRAC - k;
        if (sh >= 0) begin
            if (sh >= 64) return '0;
            prod = prod >> sh;
            return (prod > U32MAX) ? U32MAX : prod[31:0];
        end
        if (prod == 0) return '0;
        if (-sh >= 32 || prod > (64'(U32MAX) >> (-sh))) return U32MAX;
        prod = prod << (-sh);
        return prod[31:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res, bit_w;
        res   = '0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v   = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    // one sample: advance the path, close path and block when due
    task automatic take_sample(input logic signed [15:0] z);
        longint      x;
        logic [63:0] payoff, avg, sq, mean, msq, mean2, var_w;
        int unsigned steps, paths, disc, n;
        t_estimate   est;
        x = longint'(drift_q) + ((longint'(vol_q) * longint'(z)) >>> SAMPLE_FRAC_BITS);
        price_q = grow_price(price_q, x);
        steps = (steps_q == 0) ? 1 : steps_q;
        if (steps > MAX_STEPS) steps = MAX_STEPS;
        step_cnt++;
        if (step_cnt < steps) return;

        if (put_q) payoff = (strike_q > price_q) ? 64'(strike_q - price_q) : 64'd0;
        else       payoff = (price_q > strike_q) ? 64'(price_q - strike_q) : 64'd0;
        disc = (disc_q > DISC_ONE) ? DISC_ONE : disc_q;
        payoff_sum = payoff_sum + ((payoff * disc) >> 16);
        price_q  = spot_q;
        step_cnt = 0;
        path_cnt++;

        paths = (paths_q == 0) ? 1 : paths_q;
        if (paths > MAX_PATHS) paths = MAX_PATHS;
        if (path_cnt < paths) return;

        avg = payoff_sum / paths;
        if (avg > U32MAX) avg = U32MAX;
        payoff_sum = '0;
        path_cnt   = 0;

        n        = block_cnt;
        mean_sum = (mean_sum + avg) & 64'hFFFF_FFFF_FFFF;
        sq       = (avg * avg) >> PRICE_FRAC_BITS;
        sq_sum   = (sq_sum > ALL_ONES - sq) ? ALL_ONES : sq_sum + sq;
        mean     = mean_sum / (n + 1);
        if (mean > U32MAX) mean = U32MAX;
        msq   = sq_sum / (n + 1);
        mean2 = (mean * mean) >> PRICE_FRAC_BITS;

        est.block_number = n[15:0];
        est.running_mean = mean[31:0];
        if (n == 0) begin
            est.standard_error = '0;
        end else begin
            var_w = (msq > mean2) ? msq - mean2 : 64'd0;
            var_w = var_w / n;
            if (var_w > (ALL_ONES >> PRICE_FRAC_BITS)) var_w = ALL_ONES >> PRICE_FRAC_BITS;
            sq = int_sqrt(var_w << PRICE_FRAC_BITS);
            est.standard_error = sq[31:0];
        end
        estimates_q.insert(estimates_q.size(), est);

        // a run restarts after block index 65535
        if (n >= 16'hFFFF) begin
            block_cnt = 0;
            mean_sum  = '0;
            sq_sum    = '0;
        end else begin
            block_cnt = n + 1;
        end
    endtask

    always @(posedge i_clk) begin
        t_estimate est;
        if (!i_rst_n) begin
            drift_q    <= '0;
            vol_q      <= 30'd26843546;
            disc_q     <= 17'd59298;
            spot_q     <= 32'd6553600;
            strike_q   <= 32'd6553600;
            put_q      <= 1'b0;
            steps_q    <= 9'd1;
            paths_q    <= 21'd10000;
            price_q    = 32'd6553600;
            step_cnt   = 0;
            payoff_sum = '0;
            path_cnt   = 0;
            block_cnt  = 0;
            mean_sum   = '0;
            sq_sum     = '0;
            estimates_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DRIFT:    drift_q  <= i_cfg_data[30:0];
                    REG_VOL:      vol_q    <= i_cfg_data[29:0];
                    REG_DISCOUNT: disc_q   <= i_cfg_data[16:0];
                    REG_SPOT:     spot_q   <= i_cfg_data;
                    REG_STRIKE:   strike_q <= i_cfg_data;
                    REG_PUT:      put_q    <= i_cfg_data[0];
                    REG_STEPS:    steps_q  <= i_cfg_data[8:0];
                    REG_PATHS:    paths_q  <= i_cfg_data[20:0];
                    default: ;
                endcase
            end
            if (gauss_ch.valid && gauss_ch.ready) take_sample(gauss_ch.gauss_sample);
            if (result_ch.valid && result_ch.ready) begin
                if (estimates_q.size() == 0) begin
                    $error("unexpected result transaction, block_number %0d",
                           result_ch.block_number);
                    fails++;
                end else begin
                    est = estimates_q.pop_front();
                    if (result_ch.block_number !== est.block_number) begin
                        $error("block_number: expected %0d, got %0d",
                               est.block_number, result_ch.block_number);
                        fails++;
                    end
                    if (result_ch.running_mean !== est.running_mean) begin
                        $error("running_mean: expected %0d, got %0d",
                               est.running_mean, result_ch.running_mean);
                        fails++;
                    end
                    if (result_ch.standard_error !== est.standard_error) begin
                        $error("standard_error: expected %0d, got %0d",
                               est.standard_error, result_ch.standard_error);
                        fails++;
                    end
                end
            end
        end
    end

    initial fails = 0;

endmodule

// ----- verif/monte_carlo_option_pricer_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// monte_carlo_option_pricer_tb
// Stimulus and verdict for the Monte Carlo option pricer.
// ============================================================================
// A short directed set hits sample extremes, saturation, out-of-range
// register values and registers changed mid path/mid block; then random
// phases with fresh settings send 1320 sample transactions. Both
// channels idle at random, and once the result side holds off long enough
// to back the pricer up into its input. The checker does all prediction.
// ============================================================================
module monte_carlo_option_pricer_tb;
    import mcop_pkg::*;

    localparam int SETTLE_CYCLES = 400;   // block end plus one sample, with margin
    localparam int WATCHDOG_MAX  = 20000; // longest hold-off plus block latency, about x6
    localparam int LONG_HOLD     = 3000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    mcop_in_if  gauss_ch ();
    mcop_out_if result_ch ();

    int fail_count;
    int pending;
    int idle_cycles;
    bit hold_request;   // asks the result side for one long hold-off
    bit tx_burst;       // sample side sends with no gaps
    bit rx_burst;       // result side never stalls

    monte_carlo_option_pricer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_gauss    (gauss_ch),
        .o_result   (result_ch)
    );

    monte_carlo_option_pricer_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .gauss_ch     (gauss_ch),
        .result_ch    (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (gauss_ch.valid && gauss_ch.ready)
            || (result_ch.valid && result_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_MAX) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stall per transaction, one long hold-off on request
    initial begin
        int gap;
        result_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = rx_burst ? 0 : $urandom_range(0, 11);
            if (hold_request) begin
                gap = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (gap > 0) begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
        end
    end

    task automatic send_sample(input logic [15:0] z);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            gauss_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        gauss_ch.valid        <= 1'b1;
        gauss_ch.gauss_sample <= z;
        do @(posedge i_clk); while (!gauss_ch.ready);
    endtask

    // drop valid, drain every expected estimate, then let the last sample
    // and any block end finish in the pricer before registers change
    task automatic wait_idle();
        gauss_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic program_all(input logic [31:0] drift, input logic [31:0] vol,
                               input logic [31:0] disc, input logic [31:0] spot,
                               input logic [31:0] strike, input logic [31:0] put,
                               input logic [31:0] steps, input logic [31:0] paths);
        write_reg(REG_DRIFT, drift);
        write_reg(REG_VOL, vol);
        write_reg(REG_DISCOUNT, disc);
        write_reg(REG_SPOT, spot);
        write_reg(REG_STRIKE, strike);
        write_reg(REG_PUT, put);
        write_reg(REG_STEPS, steps);
        write_reg(REG_PATHS, paths);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_price();
        return ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(1 << 20, 1 << 24);
    endfunction

    initial begin
        logic [31:0] drift;
        logic [31:0] vol;
        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_idx             <= '0;
        i_cfg_data            <= '0;
        gauss_ch.valid        <= 1'b0;
        gauss_ch.gauss_sample <= '0;
        hold_request = 1'b0;
        tx_burst     = 1'b0;
        rx_burst     = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // at-the-money call, full discount, one step per path, one path per block
        program_all(32'd0, 32'd26843546, 32'd65536, 32'd100 << 16, 32'd100 << 16,
                    32'd0, 32'd1, 32'd1);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        wait_idle();

        // largest drift and vol: price saturates; discount above one;
        // zero steps and paths act as one; put on saturated price
        program_all(32'h3FFF_FFFF, 32'h3FFF_FFFF, 32'h1FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        wait_idle();

        // most negative drift, zero vol/spot/strike; steps and paths beyond
        // their caps, then cut short mid path and mid block
        program_all(32'h4000_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                    32'h1FF, 32'h1F_FFFF);
        repeat (4) send_sample(16'($urandom()));
        wait_idle();
        write_reg(REG_STEPS, 32'd1);
        write_reg(REG_SPOT, 32'hFFFF_FFFF);
        i_cfg_we <= 1'b0;
        send_sample(16'h1234);
        wait_idle();
        write_reg(REG_PATHS, 32'd1);
        i_cfg_we <= 1'b0;
        send_sample(16'hEDCB);
        send_sample(16'h0F0F);
        wait_idle();

        // random phases with fresh settings
        for (int ph = 0; ph < 12; ph++) begin
            drift = ($urandom_range(0, 5) == 0) ? $urandom()
                                                : 32'($urandom_range(0, 4000000)) - 2000000;
            vol   = ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 60000000);
            program_all(drift, vol, $urandom_range(0, 32'h1FFFF), rand_price(), rand_price(),
                        $urandom_range(0, 1),
                        ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20)
                                                    : $urandom_range(1, 4),
                        ($urandom_range(0, 5) == 0) ? $urandom_range(0, 12)
                                                    : $urandom_range(1, 4));
            // phase 3: one result per sample and a stalled receiver fill the pricer
            if (ph == 3) begin
                write_reg(REG_STEPS, 32'd1);
                write_reg(REG_PATHS, 32'd1);
                i_cfg_we <= 1'b0;
                hold_request = 1'b1;
            end
            tx_burst = (ph % 4 == 1) || (ph == 3);
            rx_burst = (ph % 4 == 2);
            for (int n = 0; n < 110; n++) begin
                send_sample(($urandom_range(0, 3) == 0)
                            ? 16'($urandom_range(0, 2048)) - 16'd1024 : 16'($urandom()));
            end
            wait_idle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
